// ----- rtl/kft_pkg.sv -----
// Shared types and field widths for the keyed table with oldest-entry replacement.
// No dependencies.
package kft_pkg;

   localparam int KEY_W    = 30;
   localparam int DATA_W   = 64;
   localparam int ACTION_W = 2;
   localparam int POSOUT_W = 3;
   localparam int COUNT_W  = 4;

   typedef enum logic [ACTION_W-1:0] {
      ACT_UPDATE  = 2'd0,
      ACT_INSERT  = 2'd1,
      ACT_REPLACE = 2'd2
   } action_type;

endpackage

// ----- rtl/keyed_table_fifo_replace_unit.sv -----
// Top level of the keyed table: key memory scan, update/insert/replace control.
// Depends on kft_pkg.
//
//   channel  ports                                    transfer when
//   request  start, busy, req_vessel_key, req_payload start & !busy
//   result   rsp_valid, rsp_action, rsp_position,     rsp_valid (one cycle)
//            rsp_entry_count
//
// Entries live in a circular buffer addressed from the oldest slot; dropping the
// oldest entry moves that pointer instead of shifting data.
// busy stays high while the held entries are scanned:
// the key memory's single read port streams one entry per cycle through the compare.
// The result strobes in the first cycle that busy is low; the next start can be taken then.
// Reset empties the table at once; key and payload memories are not cleared.
module keyed_table_fifo_replace_unit #(
   parameter int TABLE_ENTRIES = 8,
   parameter int PAYLOAD_BITS  = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [kft_pkg::KEY_W-1:0]     req_vessel_key,
   input  logic [kft_pkg::DATA_W-1:0]    req_payload,
   output logic                          rsp_valid,
   output logic [kft_pkg::ACTION_W-1:0]  rsp_action,
   output logic [kft_pkg::POSOUT_W-1:0]  rsp_position,
   output logic [kft_pkg::COUNT_W-1:0]   rsp_entry_count
);
   import kft_pkg::*;

   localparam int POS_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int EXT_W = POS_W + CNT_W + COUNT_W + POSOUT_W;
   localparam logic [POS_W-1:0] LAST_SLOT = POS_W'(TABLE_ENTRIES - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(TABLE_ENTRIES);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   logic [KEY_W-1:0]        key_mem [TABLE_ENTRIES];
   logic [PAYLOAD_BITS-1:0] pay_mem [TABLE_ENTRIES];

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [POS_W-1:0]        head_ff, head_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic [POS_W-1:0]        scan_phys_ff, scan_phys_in;
   logic                    rd_pend_ff, rd_pend_in;
   logic [POS_W-1:0]        rd_pos_ff, rd_pos_in;
   logic [POS_W-1:0]        rd_phys_ff, rd_phys_in;
   logic [KEY_W-1:0]        key_ff;
   logic [PAYLOAD_BITS-1:0] data_ff;
   logic [KEY_W-1:0]        key_rdata_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   action_type              action_ff, action_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [CNT_W-1:0]        cnt_out_ff, cnt_out_in;

   logic                    accept;
   logic                    hit_now;
   logic                    rd_en;
   logic                    key_we;
   logic                    pay_we;
   logic [POS_W-1:0]        wr_addr;
   logic [EXT_W-1:0]        pos_ext;
   logic [EXT_W-1:0]        cnt_ext;

   function automatic logic [POS_W-1:0] wrap_inc(input logic [POS_W-1:0] p);
      logic [POS_W-1:0] r;
      if (p == LAST_SLOT) begin
         r = '0;
      end else begin
         r = p + POS_W'(1);
      end
      return r;
   endfunction

   assign accept  = start && (state_ff == ST_IDLE);
   assign busy    = (state_ff != ST_IDLE);
   assign hit_now = rd_pend_ff && (key_rdata_ff == key_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      idx_in       = idx_ff;
      scan_phys_in = scan_phys_ff;
      rd_pend_in   = 1'b0;
      rd_pos_in    = rd_pos_ff;
      rd_phys_in   = rd_phys_ff;
      rsp_valid_in = 1'b0;
      action_in    = action_ff;
      pos_in       = pos_ff;
      cnt_out_in   = cnt_out_ff;
      rd_en        = 1'b0;
      key_we       = 1'b0;
      pay_we       = 1'b0;
      wr_addr      = scan_phys_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in     = ST_SCAN;
               idx_in       = '0;
               scan_phys_in = head_ff;
            end
         end
         ST_SCAN: begin
            if (hit_now) begin
               pay_we       = 1'b1;
               wr_addr      = rd_phys_ff;
               action_in    = ACT_UPDATE;
               pos_in       = rd_pos_ff;
               cnt_out_in   = count_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (idx_ff < count_ff) begin
               rd_en        = 1'b1;
               rd_pend_in   = 1'b1;
               rd_pos_in    = idx_ff[POS_W-1:0];
               rd_phys_in   = scan_phys_ff;
               idx_in       = idx_ff + CNT_W'(1);
               scan_phys_in = wrap_inc(scan_phys_ff);
            end else begin
               key_we       = 1'b1;
               pay_we       = 1'b1;
               wr_addr      = scan_phys_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (count_ff < FULL_CNT) begin
                  action_in  = ACT_INSERT;
                  pos_in     = count_ff[POS_W-1:0];
                  count_in   = count_ff + CNT_W'(1);
                  cnt_out_in = count_ff + CNT_W'(1);
               end else begin
                  action_in  = ACT_REPLACE;
                  pos_in     = LAST_SLOT;
                  head_in    = wrap_inc(head_ff);
                  cnt_out_in = count_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      scan_phys_ff <= scan_phys_in;
      rd_pos_ff    <= rd_pos_in;
      rd_phys_ff   <= rd_phys_in;
      action_ff    <= action_in;
      pos_ff       <= pos_in;
      cnt_out_ff   <= cnt_out_in;
      if (accept) begin
         key_ff  <= req_vessel_key;
         data_ff <= req_payload[PAYLOAD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[wr_addr] <= key_ff;
      end
      if (rd_en) begin
         key_rdata_ff <= key_mem[scan_phys_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (pay_we) begin
         pay_mem[wr_addr] <= data_ff;
      end
   end

   assign pos_ext = EXT_W'(pos_ff);
   assign cnt_ext = EXT_W'(cnt_out_ff);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_action      = action_ff;
   assign rsp_position    = pos_ext[POSOUT_W-1:0];
   assign rsp_entry_count = cnt_ext[COUNT_W-1:0];

endmodule

// ----- tb/tb_keyed_table_fifo_replace_unit.sv -----
// Testbench for keyed_table_fifo_replace_unit: sends vessel records over start/busy, checks
// every result strobe against typed rows or an in-bench model of the age-ordered key table.
// Depends on kft_pkg and the RTL of the unit.
module tb_keyed_table_fifo_replace_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import kft_pkg::*;

   localparam int TABLE_ENTRIES = 8;
   localparam int PAYLOAD_BITS  = 64;
   localparam int RANDOM_ITEMS  = 800;
   localparam int CALM_ITEMS    = 120;
   localparam int SEGMENT_ITEMS = 100;
   localparam int POOL_SIZE     = 11;
   localparam int IDLE_LIMIT    = 400;
   localparam int N_DIRECTED    = 16;

   localparam logic [KEY_W-1:0]  KEY_ONES  = '1;
   localparam logic [KEY_W-1:0]  KEY_TOP   = 30'd999999999;
   localparam logic [DATA_W-1:0] DATA_ONES = '1;

   typedef struct packed {
      action_type            action;
      logic [POSOUT_W-1:0]   position;
      logic [COUNT_W-1:0]    count;
   } table_result_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [DATA_W-1:0]  payload;
      logic               typed;
      table_result_type   res;
   } record_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [KEY_W-1:0]     req_vessel_key;
   logic [DATA_W-1:0]    req_payload;
   logic                 rsp_valid;
   logic [ACTION_W-1:0]  rsp_action;
   logic [POSOUT_W-1:0]  rsp_position;
   logic [COUNT_W-1:0]   rsp_entry_count;

   logic [KEY_W-1:0]         model_keys [TABLE_ENTRIES];
   logic [PAYLOAD_BITS-1:0]  model_payloads [TABLE_ENTRIES];
   int                       model_count;

   table_result_type  pending_results [$];
   record_row_type    directed_rows [N_DIRECTED];
   logic [KEY_W-1:0]  key_pool [POOL_SIZE];

   int mismatch_count;
   int idle_cycles;
   int records_sent;
   int updates_seen;
   int inserts_seen;
   int replaces_seen;

   keyed_table_fifo_replace_unit #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .PAYLOAD_BITS  (PAYLOAD_BITS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_vessel_key  (req_vessel_key),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_action      (rsp_action),
      .rsp_position    (rsp_position),
      .rsp_entry_count (rsp_entry_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic table_result_type predict_table_write(input logic [KEY_W-1:0] key,
         input logic [DATA_W-1:0] payload);
      table_result_type res;
      int hit_pos;
      hit_pos = -1;
      for (int i = 0; i < model_count; i++) begin
         if (hit_pos < 0 && model_keys[i] == key) hit_pos = i;
      end
      if (hit_pos >= 0) begin
         model_payloads[hit_pos] = PAYLOAD_BITS'(payload);
         res.action   = ACT_UPDATE;
         res.position = POSOUT_W'(hit_pos);
      end else if (model_count < TABLE_ENTRIES) begin
         model_keys[model_count]     = key;
         model_payloads[model_count] = PAYLOAD_BITS'(payload);
         res.action   = ACT_INSERT;
         res.position = POSOUT_W'(model_count);
         model_count++;
      end else begin
         for (int i = 1; i < TABLE_ENTRIES; i++) begin
            model_keys[i-1]     = model_keys[i];
            model_payloads[i-1] = model_payloads[i];
         end
         model_keys[TABLE_ENTRIES-1]     = key;
         model_payloads[TABLE_ENTRIES-1] = PAYLOAD_BITS'(payload);
         res.action   = ACT_REPLACE;
         res.position = POSOUT_W'(TABLE_ENTRIES - 1);
      end
      res.count = COUNT_W'(model_count);
      return res;
   endfunction

   // busy only moves at the rising edge, so it is stable when looked at on the falling edge
   task automatic send_record(input logic [KEY_W-1:0] key, input logic [DATA_W-1:0] payload,
         input int gap, input logic typed, input table_result_type typed_res);
      table_result_type res;
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start          <= 1'b1;
      req_vessel_key <= key;
      req_payload    <= payload;
      while (busy) @(negedge clock);
      @(posedge clock);
      res = predict_table_write(key, payload);
      pending_results.push_back(typed ? typed_res : res);
      records_sent++;
   endtask

   task automatic check_field(input string name, input int unsigned want,
         input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // result checking and stall watchdog
   always @(posedge clock) begin
      table_result_type want;
      if (!reset) begin
         if ((start && !busy) || rsp_valid) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
         end
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, %s %0d pos %0d count %0d",
                        $time, "actual action", rsp_action, rsp_position,
                        rsp_entry_count);
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("action", want.action, rsp_action);
               check_field("position", want.position, rsp_position);
               check_field("entry_count", want.count, rsp_entry_count);
            end
            case (action_type'(rsp_action))
               ACT_UPDATE:  updates_seen++;
               ACT_INSERT:  inserts_seen++;
               ACT_REPLACE: replaces_seen++;
               default: ;
            endcase
         end
      end
   end

   initial begin
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] payload;
      int idle_pct;
      int gap;

      reset          = 1'b1;
      start          = 1'b0;
      req_vessel_key = '0;
      req_payload    = '0;
      model_count    = 0;
      mismatch_count = 0;
      idle_cycles    = 0;
      records_sent   = 0;
      updates_seen   = 0;
      inserts_seen   = 0;
      replaces_seen  = 0;

      directed_rows = '{
         '{30'd0,       64'd0,                  1'b1, '{ACT_INSERT,  3'd0, 4'd1}},
         '{30'd0,       DATA_ONES,              1'b1, '{ACT_UPDATE,  3'd0, 4'd1}},
         '{KEY_ONES,    64'h5555_5555_5555_5555, 1'b1, '{ACT_INSERT,  3'd1, 4'd2}},
         '{KEY_TOP,     64'hAAAA_AAAA_AAAA_AAAA, 1'b1, '{ACT_INSERT,  3'd2, 4'd3}},
         '{KEY_ONES,    64'd0,                  1'b1, '{ACT_UPDATE,  3'd1, 4'd3}},
         '{30'd1,       64'h0123_4567_89AB_CDEF, 1'b1, '{ACT_INSERT,  3'd3, 4'd4}},
         '{30'd2,       64'hFEDC_BA98_7654_3210, 1'b1, '{ACT_INSERT,  3'd4, 4'd5}},
         '{30'd3,       64'h8000_0000_0000_0001, 1'b1, '{ACT_INSERT,  3'd5, 4'd6}},
         '{30'd4,       64'h7FFF_FFFF_FFFF_FFFE, 1'b1, '{ACT_INSERT,  3'd6, 4'd7}},
         '{30'd5,       64'h0000_FFFF_0000_FFFF, 1'b1, '{ACT_INSERT,  3'd7, 4'd8}},
         '{30'h2AAAAAAA, 64'hFFFF_0000_FFFF_0000, 1'b1, '{ACT_REPLACE, 3'd7, 4'd8}},
         '{30'd0,       64'h1111_2222_3333_4444, 1'b1, '{ACT_REPLACE, 3'd7, 4'd8}},
         '{KEY_TOP,     64'h5A5A_5A5A_A5A5_A5A5, 1'b0, '{ACT_UPDATE,  3'd0, 4'd0}},
         '{KEY_ONES,    DATA_ONES,              1'b0, '{ACT_UPDATE,  3'd0, 4'd0}},
         '{30'd0,       64'd0,                  1'b0, '{ACT_UPDATE,  3'd0, 4'd0}},
         '{30'h15555555, 64'hC3C3_3C3C_C3C3_3C3C, 1'b0, '{ACT_UPDATE,  3'd0, 4'd0}}
      };

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 17) : 0;
         send_record(directed_rows[i].key, directed_rows[i].payload, gap,
                     directed_rows[i].typed, directed_rows[i].res);
      end

      idle_pct = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % SEGMENT_ITEMS == 0) begin
            idle_pct = $urandom_range(0, 3) * 20;
            foreach (key_pool[k]) key_pool[k] = KEY_W'($urandom);
            key_pool[0] = KEY_TOP;
         end
         if ($urandom_range(0, 9) < 7) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         else key = KEY_W'($urandom);
         payload = {$urandom, $urandom};
         if (n < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(1, 100) <= idle_pct)
            gap = $urandom_range(1, 17);
         else
            gap = 0;
         send_record(key, payload, gap, 1'b0, '0);
      end

      @(negedge clock);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TABLE_ENTRIES + 4) @(posedge clock);

      $display("Sent %0d records; results seen: %0d updates, %0d inserts,",
               records_sent, updates_seen, inserts_seen);
      $display("and %0d oldest-entry replacements", replaces_seen);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/kft_pkg.sv
rtl/keyed_table_fifo_replace_unit.sv
tb/tb_keyed_table_fifo_replace_unit.sv
